// ===== design/kaau_pkg.sv =====
// Shared types, codes and defaults for the k-means assign/update engine.
package kaau_pkg;

	localparam int MAX_CLUSTERS_DEF = 16;
	localparam int COUNT_BITS_DEF   = 16;
	localparam logic [4:0] CLUSTERS_RESET = 5'd8;

	localparam logic [1:0] MODE_SEED   = 2'd0;
	localparam logic [1:0] MODE_ASSIGN = 2'd1;
	localparam logic [1:0] MODE_RECOMP = 2'd2;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [15:0] pl;
		logic signed [15:0] pa;
		logic signed [15:0] pb;
		logic [3:0]         seed_index;
		logic [3:0]         prev_index;
		logic               prev_valid;
	} cmd_t;

	typedef struct packed {
		logic vld;
		cmd_t cmd;
	} q_head_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_A_SCAN,
		ST_A_DRAIN,
		ST_A_RD,
		ST_A_UPD,
		ST_R_RD,
		ST_R_LOAD,
		ST_R_DIV,
		ST_R_OUT
	} eng_state_t;

endpackage

// ===== design/kaau_front.sv =====
// Front end: accepts commands, drops unused codes, two-entry command queue.
module kaau_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [1:0]           mode,
	input  logic signed [15:0]   point_l,
	input  logic signed [15:0]   point_a,
	input  logic signed [15:0]   point_b,
	input  logic [3:0]           seed_index,
	input  logic [3:0]           previous_index,
	input  logic                 previous_valid,
	input  logic                 pop,
	output logic                 busy,
	output kaau_pkg::q_head_t    head
);

	kaau_pkg::cmd_t ent_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	logic           accept;
	logic           push;
	logic           do_pop;

	assign busy   = (cnt_q == 2'd2);
	assign accept = start && !busy;
	assign push   = accept && (mode == kaau_pkg::MODE_SEED || mode == kaau_pkg::MODE_ASSIGN ||
		mode == kaau_pkg::MODE_RECOMP);
	assign do_pop = pop && (cnt_q != 2'd0);

	assign head.vld = (cnt_q != 2'd0);
	assign head.cmd = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= '{mode: mode, pl: point_l, pa: point_a, pb: point_b,
				seed_index: seed_index, prev_index: previous_index, prev_valid: previous_valid};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop) rd_ptr_q <= ~rd_ptr_q;
			case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== design/kaau_div.sv =====
// Restoring divider, one quotient bit per cycle.
module kaau_div #(
	parameter int DW = 33,
	parameter int VW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);

	localparam int CNT_W = $clog2(DW + 1);

	logic [VW:0]    rem_q;
	logic [DW-1:0]  quo_q;
	logic [VW-1:0]  dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [VW:0]    sh;
	logic [VW+1:0]  trial;

	assign sh       = {rem_q[VW-1:0], quo_q[DW-1]};
	assign trial    = {1'b0, sh} - {2'b00, dvs_q};
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[VW+1]) begin
				rem_q <= trial[VW:0];
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= sh;
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

endmodule

// ===== design/kaau_engine.sv =====
// Back end: centroid seeding and search, running sums, and end-of-pass recompute.
module kaau_engine #(
	parameter int MAX_CLUSTERS = kaau_pkg::MAX_CLUSTERS_DEF,
	parameter int COUNT_BITS   = kaau_pkg::COUNT_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [4:0]          clusters,
	input  kaau_pkg::q_head_t   head,
	output logic                pop,
	output logic                result_strobe,
	output logic [3:0]          cluster_index,
	output logic signed [15:0]  centroid_l,
	output logic signed [15:0]  centroid_a,
	output logic signed [15:0]  centroid_b,
	output logic                changed,
	output logic                last
);

	localparam int IDX_W = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
	localparam int KW    = $clog2(MAX_CLUSTERS + 1);
	localparam int CW    = (KW > 5) ? KW : 5;
	localparam int XW    = (IDX_W > 4) ? IDX_W : 4;
	localparam int DW    = 33;

	kaau_pkg::eng_state_t state_q, state_d;
	kaau_pkg::cmd_t       cmd_q;

	// centroid memory and valid bits
	logic signed [15:0] cent_l_mem [MAX_CLUSTERS];
	logic signed [15:0] cent_a_mem [MAX_CLUSTERS];
	logic signed [15:0] cent_b_mem [MAX_CLUSTERS];
	logic [MAX_CLUSTERS-1:0] cent_vld_q;
	// running sums and counts
	logic signed [31:0] sum_l_mem [MAX_CLUSTERS];
	logic signed [31:0] sum_a_mem [MAX_CLUSTERS];
	logic signed [31:0] sum_b_mem [MAX_CLUSTERS];
	logic [COUNT_BITS-1:0] cnt_mem [MAX_CLUSTERS];
	logic [MAX_CLUSTERS-1:0] sum_vld_q;

	logic [CW-1:0]    k_raw, k_eff;
	logic [IDX_W-1:0] k_m1;
	logic [IDX_W-1:0] i_q;
	logic [IDX_W-1:0] best_q;
	logic [34:0]      best_d_q;
	logic             pass_changed_q;

	logic             cw_en;
	logic [IDX_W-1:0] cw_addr;
	logic signed [15:0] cw_l, cw_a, cw_b;
	logic             seed_ok;

	// search pipeline
	logic               v_s1, last_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic signed [15:0] c_l_s1, c_a_s1, c_b_s1;
	logic               cv_s1;
	logic               v_s2, last_s2;
	logic [IDX_W-1:0]   idx_s2;
	logic [33:0]        sq_l_s2, sq_a_s2, sq_b_s2;
	logic signed [15:0] ce_l, ce_a, ce_b;
	logic signed [16:0] d_l, d_a, d_b;
	logic signed [33:0] p_l, p_a, p_b;
	logic [34:0]        dist_sq;

	// sum read port
	logic [IDX_W-1:0]      sr_addr;
	logic signed [31:0]    sr_l, sr_a, sr_b;
	logic [COUNT_BITS-1:0] sr_n;
	logic                  sr_vld;
	logic signed [31:0]    se_l, se_a, se_b;
	logic [COUNT_BITS-1:0] se_n;
	logic signed [31:0]    nl, na, nb;

	// divide
	logic              div_start;
	logic [DW-1:0]     dvd_l, dvd_a, dvd_b;
	logic [DW-1:0]     q_l, q_a, q_b;
	logic              done_l, done_a, done_b;
	logic [2:0]        sgn_q;
	logic              nzero_q;
	logic signed [15:0] m_l, m_a, m_b;
	logic              fin;

	function automatic logic signed [31:0] sat_add(logic signed [31:0] s,
		logic signed [15:0] p);
		logic signed [32:0] t;
		t = 33'(s) + 33'(p);
		if (t[32] != t[31]) return t[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		return t[31:0];
	endfunction

	function automatic logic signed [15:0] mean_sat(logic neg, logic [DW-1:0] q);
		if (!neg) return (q > DW'(32767)) ? 16'sh7FFF : q[15:0];
		return (q > DW'(32768)) ? 16'sh8000 : 16'(-q[15:0]);
	endfunction

	function automatic logic [DW-1:0] dividend_of(logic signed [31:0] s,
		logic [COUNT_BITS-1:0] n);
		logic [31:0] mag;
		mag = s[31] ? 32'(-s) : 32'(s);
		return DW'(mag) + DW'(n >> 1);
	endfunction

	assign k_raw = CW'(clusters);
	assign k_eff = (k_raw == '0) ? CW'(1) :
		((k_raw > CW'(MAX_CLUSTERS)) ? CW'(MAX_CLUSTERS) : k_raw);
	assign k_m1  = IDX_W'(k_eff - CW'(1));
	assign fin   = (i_q == k_m1);

	// next state
	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		div_start = 1'b0;
		case (state_q)
			kaau_pkg::ST_IDLE: begin
				if (head.vld) begin
					pop = 1'b1;
					case (head.cmd.mode)
						kaau_pkg::MODE_ASSIGN: state_d = kaau_pkg::ST_A_SCAN;
						kaau_pkg::MODE_RECOMP: state_d = kaau_pkg::ST_R_RD;
						default:               state_d = kaau_pkg::ST_IDLE;
					endcase
				end
			end
			kaau_pkg::ST_A_SCAN:  if (fin) state_d = kaau_pkg::ST_A_DRAIN;
			kaau_pkg::ST_A_DRAIN: if (v_s2 && last_s2) state_d = kaau_pkg::ST_A_RD;
			kaau_pkg::ST_A_RD:    state_d = kaau_pkg::ST_A_UPD;
			kaau_pkg::ST_A_UPD:   state_d = kaau_pkg::ST_IDLE;
			kaau_pkg::ST_R_RD:    state_d = kaau_pkg::ST_R_LOAD;
			kaau_pkg::ST_R_LOAD: begin
				div_start = 1'b1;
				state_d   = kaau_pkg::ST_R_DIV;
			end
			kaau_pkg::ST_R_DIV:   if (done_l && done_a && done_b) state_d = kaau_pkg::ST_R_OUT;
			kaau_pkg::ST_R_OUT:   state_d = fin ? kaau_pkg::ST_IDLE : kaau_pkg::ST_R_RD;
			default:              state_d = kaau_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= kaau_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (pop) cmd_q <= head.cmd;
	end

	// centroid writes: seed in idle, mean at recompute output
	assign seed_ok = (7'(head.cmd.seed_index) < 7'(MAX_CLUSTERS));
	always_comb begin
		cw_en   = 1'b0;
		cw_addr = i_q;
		cw_l    = m_l;
		cw_a    = m_a;
		cw_b    = m_b;
		if (state_q == kaau_pkg::ST_IDLE) begin
			cw_en   = pop && head.cmd.mode == kaau_pkg::MODE_SEED && seed_ok;
			cw_addr = IDX_W'(head.cmd.seed_index);
			cw_l    = head.cmd.pl;
			cw_a    = head.cmd.pa;
			cw_b    = head.cmd.pb;
		end else if (state_q == kaau_pkg::ST_R_OUT) begin
			cw_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cw_en) begin
			cent_l_mem[cw_addr] <= cw_l;
			cent_a_mem[cw_addr] <= cw_a;
			cent_b_mem[cw_addr] <= cw_b;
		end
		c_l_s1 <= cent_l_mem[i_q];
		c_a_s1 <= cent_a_mem[i_q];
		c_b_s1 <= cent_b_mem[i_q];
	end

	// search pipeline: read, square, accumulate and compare
	assign ce_l = cv_s1 ? c_l_s1 : '0;
	assign ce_a = cv_s1 ? c_a_s1 : '0;
	assign ce_b = cv_s1 ? c_b_s1 : '0;
	assign d_l  = 17'(cmd_q.pl) - 17'(ce_l);
	assign d_a  = 17'(cmd_q.pa) - 17'(ce_a);
	assign d_b  = 17'(cmd_q.pb) - 17'(ce_b);
	assign p_l  = d_l * d_l;
	assign p_a  = d_a * d_a;
	assign p_b  = d_b * d_b;
	assign dist_sq = 35'(sq_l_s2) + 35'(sq_a_s2) + 35'(sq_b_s2);

	always_ff @(posedge clk) begin
		idx_s1  <= i_q;
		cv_s1   <= cent_vld_q[i_q];
		idx_s2  <= idx_s1;
		sq_l_s2 <= p_l;
		sq_a_s2 <= p_a;
		sq_b_s2 <= p_b;
		if (v_s2 && (idx_s2 == '0 || dist_sq < best_d_q)) begin
			best_q   <= idx_s2;
			best_d_q <= dist_sq;
		end
	end

	// sum memory
	assign sr_addr = (state_q == kaau_pkg::ST_A_RD) ? best_q : i_q;
	assign se_l = sr_vld ? sr_l : '0;
	assign se_a = sr_vld ? sr_a : '0;
	assign se_b = sr_vld ? sr_b : '0;
	assign se_n = sr_vld ? sr_n : '0;
	assign nl   = sat_add(se_l, cmd_q.pl);
	assign na   = sat_add(se_a, cmd_q.pa);
	assign nb   = sat_add(se_b, cmd_q.pb);

	always_ff @(posedge clk) begin
		sr_l   <= sum_l_mem[sr_addr];
		sr_a   <= sum_a_mem[sr_addr];
		sr_b   <= sum_b_mem[sr_addr];
		sr_n   <= cnt_mem[sr_addr];
		sr_vld <= sum_vld_q[sr_addr];
		if (state_q == kaau_pkg::ST_A_UPD && !(&se_n)) begin
			sum_l_mem[best_q] <= nl;
			sum_a_mem[best_q] <= na;
			sum_b_mem[best_q] <= nb;
			cnt_mem[best_q]   <= se_n + 1'b1;
		end
	end

	// divide sums by counts
	assign dvd_l = dividend_of(se_l, se_n);
	assign dvd_a = dividend_of(se_a, se_n);
	assign dvd_b = dividend_of(se_b, se_n);

	kaau_div #(.DW(DW), .VW(COUNT_BITS)) u_div_l (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(dvd_l),
		.divisor(se_n), .done(done_l), .quotient(q_l));
	kaau_div #(.DW(DW), .VW(COUNT_BITS)) u_div_a (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(dvd_a),
		.divisor(se_n), .done(done_a), .quotient(q_a));
	kaau_div #(.DW(DW), .VW(COUNT_BITS)) u_div_b (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(dvd_b),
		.divisor(se_n), .done(done_b), .quotient(q_b));

	always_ff @(posedge clk) begin
		if (div_start) begin
			sgn_q   <= {se_l[31], se_a[31], se_b[31]};
			nzero_q <= (se_n == '0);
		end
	end

	// the three dividers run in lockstep
	assign m_l = nzero_q ? '0 : mean_sat(sgn_q[2], q_l);
	assign m_a = nzero_q ? '0 : mean_sat(sgn_q[1], q_a);
	assign m_b = nzero_q ? '0 : mean_sat(sgn_q[0], q_b);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q            <= '0;
			v_s1           <= 1'b0;
			last_s1        <= 1'b0;
			v_s2           <= 1'b0;
			last_s2        <= 1'b0;
			cent_vld_q     <= '0;
			sum_vld_q      <= '0;
			pass_changed_q <= 1'b0;
			result_strobe  <= 1'b0;
			changed        <= 1'b0;
			last           <= 1'b0;
		end else begin
			v_s1          <= (state_q == kaau_pkg::ST_A_SCAN);
			last_s1       <= (state_q == kaau_pkg::ST_A_SCAN) && fin;
			v_s2          <= v_s1;
			last_s2       <= last_s1;
			result_strobe <= 1'b0;
			changed       <= 1'b0;
			last          <= 1'b0;
			if (cw_en) cent_vld_q[cw_addr] <= 1'b1;
			case (state_q)
				kaau_pkg::ST_IDLE:   i_q <= '0;
				kaau_pkg::ST_A_SCAN: i_q <= i_q + 1'b1;
				kaau_pkg::ST_A_UPD: begin
					if (!(&se_n)) sum_vld_q[best_q] <= 1'b1;
					if (cmd_q.prev_valid && XW'(cmd_q.prev_index) != XW'(best_q))
						pass_changed_q <= 1'b1;
					result_strobe <= 1'b1;
					last          <= 1'b1;
				end
				kaau_pkg::ST_R_OUT: begin
					result_strobe <= 1'b1;
					if (fin) begin
						changed        <= pass_changed_q;
						last           <= 1'b1;
						sum_vld_q      <= '0;
						pass_changed_q <= 1'b0;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				default: i_q <= i_q;
			endcase
		end
	end

	logic [XW-1:0] out_idx;
	always_ff @(posedge clk) begin
		if (state_q == kaau_pkg::ST_A_UPD) begin
			out_idx    <= XW'(best_q);
			centroid_l <= '0;
			centroid_a <= '0;
			centroid_b <= '0;
		end else if (state_q == kaau_pkg::ST_R_OUT) begin
			out_idx    <= XW'(i_q);
			centroid_l <= m_l;
			centroid_a <= m_a;
			centroid_b <= m_b;
		end
	end
	assign cluster_index = out_idx[3:0];

endmodule

// ===== design/kmeans_assign_and_update.sv =====
// Seed: written from the queue head once the back end is idle, no result.
// Assign: the back end steps through scan, drain, sum read and sum update, then gives a result strobe.
// Recompute: per cluster, the sums are read and divided by the count in the bit-serial 33-step divider.
// Items run one at a time in the back end; a 2-entry queue holds busy low until both entries are full.
// Results are single-cycle strobes and cannot be stalled.
// Reset clears all sums, counts and centroids at once through valid bits; no sweep.
module kmeans_assign_and_update #(
	parameter int MAX_CLUSTERS = kaau_pkg::MAX_CLUSTERS_DEF,
	parameter int COUNT_BITS   = kaau_pkg::COUNT_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [4:0]         cfg_wdata,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         mode,
	input  logic signed [15:0] point_l,
	input  logic signed [15:0] point_a,
	input  logic signed [15:0] point_b,
	input  logic [3:0]         seed_index,
	input  logic [3:0]         previous_index,
	input  logic               previous_valid,
	output logic               result_strobe,
	output logic [3:0]         cluster_index,
	output logic signed [15:0] centroid_l,
	output logic signed [15:0] centroid_a,
	output logic signed [15:0] centroid_b,
	output logic               changed,
	output logic               last
);

	logic [4:0]        clusters_q;
	kaau_pkg::q_head_t head;
	logic              pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clusters_q <= kaau_pkg::CLUSTERS_RESET;
		else if (cfg_we) clusters_q <= cfg_wdata;
	end

	kaau_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .mode(mode),
		.point_l(point_l), .point_a(point_a), .point_b(point_b),
		.seed_index(seed_index), .previous_index(previous_index),
		.previous_valid(previous_valid), .pop(pop), .busy(busy), .head(head));

	kaau_engine #(.MAX_CLUSTERS(MAX_CLUSTERS), .COUNT_BITS(COUNT_BITS)) u_engine (
		.clk(clk), .arst_n(arst_n), .clusters(clusters_q), .head(head), .pop(pop),
		.result_strobe(result_strobe), .cluster_index(cluster_index),
		.centroid_l(centroid_l), .centroid_a(centroid_a), .centroid_b(centroid_b),
		.changed(changed), .last(last));

`ifndef SYNTHESIS
	a_changed_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && changed |-> last) else $error("changed without last");
	a_busy_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> head.vld) else $error("busy with empty queue");
	a_pop_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.vld) else $error("pop from empty queue");
`endif

endmodule
